### hw/rtl/rgbncc_pkg.sv
package rgbncc_pkg;

   localparam int MAX_COLORS_DEF = 16;
   localparam int RATIO_BITS_DEF = 12;

   localparam int ACT_W      = 5;
   localparam int ACT_RESET  = 16;
   localparam int ENTRY_W    = 27;
   localparam int SUM_W      = 9;
   localparam int COUNT_W    = 16;
   localparam int CHAN_W     = 8;
   localparam int DIST_W     = 20;
   localparam int CONF_W     = 10;
   localparam int INDEX_W    = 4;

   localparam int REQ_DATA_W = 120;
   localparam int RSP_DATA_W = 88;

   localparam logic CMD_LOAD     = 1'b0;
   localparam logic CMD_CLASSIFY = 1'b1;

endpackage

### hw/rtl/rgbncc_ram.sv
module rgbncc_ram #(
   parameter int WIDTH = 27,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/rgb_nearest_color_classifier.sv
// rgb nearest color classifier
// input channel req_*: one item per handshake. req_tuser is the command:
// load writes one color table entry (sum of low and high bounds per channel),
// classify takes raw clear/red/green/blue counts and yields one result item.
// result channel rsp_*: match index, gamma channels, packed color, four times
// the squared distance and a confidence in tenths of a percent.
// csr_wr_en/csr_wr_data write active_colors, the number of entries searched.
// a load item gives no result. a classify item runs, in this order, the
// bit-serial ratio divider, the gamma search, the table walk, a multiply,
// the bit-serial square root, the confidence steps and the output step;
// the walk reads the entries one at a time through the single read port
// of the table memory.
// req_tready is high only while the block is idle; the result sits in an
// output register, so a new item is accepted while an earlier result waits.
// if the receiver stalls, a finished result holds the block until taken.
// reset (synchronous) marks every table entry invalid (reads as zero), sets
// active_colors to 16 and drops any pending result.
module rgb_nearest_color_classifier #(
   parameter int MAX_COLORS = rgbncc_pkg::MAX_COLORS_DEF,
   parameter int RATIO_BITS = rgbncc_pkg::RATIO_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // entry_index, red_low, red_high, green_low, green_high, blue_low,
   // blue_high, clear_count, red_count, green_count, blue_count
   input  logic [rgbncc_pkg::REQ_DATA_W-1:0] req_tdata,
   // cmd
   input  logic                              req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // match_index, gamma_red, gamma_green, gamma_blue, packed_color,
   // distance_squared_x4, confidence_tenths
   output logic [rgbncc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_wr_en,
   input  logic [rgbncc_pkg::ACT_W-1:0]      csr_wr_data
);

   import rgbncc_pkg::*;

   localparam int AW = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
   localparam int CW = $clog2(MAX_COLORS + 1);
   localparam int QW = RATIO_BITS + 1;

   // state codes
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_GAM  = 3'd2;
   localparam logic [2:0] ST_WALK = 3'd3;
   localparam logic [2:0] ST_MUL  = 3'd4;
   localparam logic [2:0] ST_SQRT = 3'd5;
   localparam logic [2:0] ST_KDIV = 3'd6;
   localparam logic [2:0] ST_DONE = 3'd7;

   localparam logic [26:0]  CONF_SCALE = 27'd100000000;
   localparam logic [23:0]  CONF_ROUND = 24'd8833;
   localparam logic [10:0]  CONF_FULL  = 11'd1000;
   // floor(x / 8834) as (x * ceil(2^38 / 8834)) >> 38, exact for x < 2^24
   localparam logic [24:0]  CONF_RECIP = 25'd31115906;
   localparam int           CONF_SHIFT = 38;

   // gamma thresholds: entry v is the least ratio whose gamma value reaches v
   typedef logic [RATIO_BITS:0] thr_type [256];

   function automatic logic gamma_reaches(int q, int v);
      logic [223:0] lhs;
      logic [223:0] rhs;
      lhs = 224'd1;
      rhs = 224'd1;
      for (int i = 0; i < 5; i++) begin
         lhs = lhs * 224'd255;
         rhs = rhs * 224'(v);
      end
      for (int i = 0; i < 11; i++) begin
         lhs = lhs * 224'(q);
      end
      rhs = rhs << (11 * RATIO_BITS);
      return lhs >= rhs;
   endfunction

   function automatic thr_type build_thr();
      thr_type t;
      real     x;
      int      c;
      t[0] = '0;
      for (int v = 1; v < 256; v++) begin
         x = (2.0 ** RATIO_BITS) * $exp($ln(v / 255.0) * 5.0 / 11.0);
         c = int'($ceil(x));
         if (c > (1 << RATIO_BITS)) c = 1 << RATIO_BITS;
         if (c < 1) c = 1;
         if (!gamma_reaches(c, v)) c = c + 1;
         if (c > 1 && gamma_reaches(c - 1, v)) c = c - 1;
         t[v] = c[RATIO_BITS:0];
      end
      return t;
   endfunction

   localparam thr_type GAMMA_THR = build_thr();

   // request fields
   logic [INDEX_W-1:0] entry_index;
   logic [CHAN_W-1:0]  red_low, red_high, green_low, green_high, blue_low, blue_high;
   logic [COUNT_W-1:0] clear_count;
   logic [COUNT_W-1:0] ch_count [3];

   assign entry_index = req_tdata[3:0];
   assign red_low     = req_tdata[11:4];
   assign red_high    = req_tdata[19:12];
   assign green_low   = req_tdata[27:20];
   assign green_high  = req_tdata[35:28];
   assign blue_low    = req_tdata[43:36];
   assign blue_high   = req_tdata[51:44];
   assign clear_count = req_tdata[67:52];
   assign ch_count[0] = req_tdata[83:68];
   assign ch_count[1] = req_tdata[99:84];
   assign ch_count[2] = req_tdata[115:100];

   // registers
   logic [2:0]         state_ff, state_in;
   logic [ACT_W-1:0]   act_ff;
   logic [4:0]         cnt_ff, cnt_in;
   logic               zero_ff, zero_in;
   logic [COUNT_W-1:0] max_ff, max_in;
   logic [COUNT_W:0]   drem_ff [3];
   logic [COUNT_W:0]   drem_in [3];
   logic [QW-1:0]      q_ff [3];
   logic [QW-1:0]      q_in [3];
   logic [CHAN_W-1:0]  lo_ff [3];
   logic [CHAN_W-1:0]  lo_in [3];
   logic [CHAN_W-1:0]  hi_ff [3];
   logic [CHAN_W-1:0]  hi_in [3];
   logic [CHAN_W-1:0]  g_ff [3];
   logic [CHAN_W-1:0]  g_in [3];
   logic [CW-1:0]      n_ff, n_in;
   logic [CW-1:0]      iss_ff, iss_in;
   logic               pend_ff, pend_in;
   logic [AW-1:0]      pidx_ff, pidx_in;
   logic               rdv_ff, rdv_in;
   logic [AW-1:0]      best_ff, best_in;
   logic [DIST_W-1:0]  bestd_ff, bestd_in;
   logic [47:0]        sqn_ff, sqn_in;
   logic [25:0]        sqrem_ff, sqrem_in;
   logic [23:0]        root_ff, root_in;
   logic [23:0]        knum_ff, knum_in;
   logic [10:0]        kq_ff, kq_in;
   logic               valid_ff [MAX_COLORS];
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic req_fire;
   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // table memory
   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic              ram_re;
   logic [AW-1:0]     ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;

   rgbncc_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MAX_COLORS),
      .AW   (AW)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   logic load_ok;
   assign load_ok   = req_fire && (req_tuser == CMD_LOAD) && (32'(entry_index) < MAX_COLORS);
   assign ram_we    = load_ok;
   assign ram_waddr = AW'(entry_index);
   assign ram_wdata = {SUM_W'(red_low) + SUM_W'(red_high),
                       SUM_W'(green_low) + SUM_W'(green_high),
                       SUM_W'(blue_low) + SUM_W'(blue_high)};
   assign ram_raddr = iss_ff[AW-1:0];
   assign ram_re    = (state_ff == ST_WALK) && (iss_ff < n_ff);

   // distance of the entry read last cycle
   logic [ENTRY_W-1:0] entry;
   logic signed [9:0]  dd [3];
   logic [DIST_W-1:0]  cand_dist;
   assign entry = rdv_ff ? ram_rdata : '0;
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         dd[c] = signed'({1'b0, g_ff[c], 1'b0}) -
                 signed'({1'b0, entry[ENTRY_W-1-c*SUM_W -: SUM_W]});
      end
      cand_dist = DIST_W'(20'(dd[0] * dd[0]) + 20'(dd[1] * dd[1]) + 20'(dd[2] * dd[2]));
   end

   // divide and root steps
   logic [COUNT_W:0] dsub [3];
   logic             dge [3];
   logic [8:0]       mid_sum [3];
   logic [CHAN_W-1:0] mid [3];
   logic [27:0]      sq_rn;
   logic [27:0]      sq_trial;
   logic [48:0]      kprod;
   logic [23:0]      knum_full;
   logic [23:0]      root_ceil;
   logic [ACT_W:0]   act_eff;
   logic [9:0]       conf;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         dge[c]     = drem_ff[c] >= (COUNT_W + 1)'(max_ff);
         dsub[c]    = dge[c] ? drem_ff[c] - (COUNT_W + 1)'(max_ff) : drem_ff[c];
         mid_sum[c] = 9'(lo_ff[c]) + 9'(hi_ff[c]) + 9'd1;
         mid[c]     = mid_sum[c][8:1];
      end
      sq_rn    = {sqrem_ff, sqn_ff[47:46]};
      sq_trial = {2'b00, root_ff, 2'b01};
      kprod    = 49'(knum_ff) * 49'(CONF_RECIP);
      root_ceil = root_ff + 24'(sqrem_ff != '0);
      knum_full = root_ceil + CONF_ROUND;
      act_eff = {1'b0, act_ff};
      if (act_ff == '0) act_eff = 6'd1;
      conf = (kq_ff >= CONF_FULL) ? '0 : 10'(CONF_FULL - kq_ff);
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      zero_in  = zero_ff;
      max_in   = max_ff;
      n_in     = n_ff;
      iss_in   = iss_ff;
      pend_in  = 1'b0;
      pidx_in  = pidx_ff;
      rdv_in   = rdv_ff;
      best_in  = best_ff;
      bestd_in = bestd_ff;
      sqn_in   = sqn_ff;
      sqrem_in = sqrem_ff;
      root_in  = root_ff;
      knum_in  = knum_ff;
      kq_in    = kq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      for (int c = 0; c < 3; c++) begin
         drem_in[c] = drem_ff[c];
         q_in[c]    = q_ff[c];
         lo_in[c]   = lo_ff[c];
         hi_in[c]   = hi_ff[c];
         g_in[c]    = g_ff[c];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_tuser == CMD_CLASSIFY) begin
               max_in = ch_count[0];
               if (ch_count[1] > max_in) max_in = ch_count[1];
               if (ch_count[2] > max_in) max_in = ch_count[2];
               zero_in = (clear_count == '0) || (max_in == '0);
               for (int c = 0; c < 3; c++) begin
                  drem_in[c] = (COUNT_W + 1)'(ch_count[c]);
                  q_in[c]    = '0;
               end
               if (32'(act_eff) > MAX_COLORS) n_in = CW'(MAX_COLORS);
               else n_in = CW'(act_eff);
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            for (int c = 0; c < 3; c++) begin
               q_in[c]    = {q_ff[c][QW-2:0], dge[c]};
               drem_in[c] = {dsub[c][COUNT_W-1:0], 1'b0};
            end
            if (32'(cnt_ff) == QW - 1) begin
               cnt_in   = '0;
               state_in = ST_GAM;
               for (int c = 0; c < 3; c++) begin
                  lo_in[c] = '0;
                  hi_in[c] = '1;
               end
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         ST_GAM: begin
            for (int c = 0; c < 3; c++) begin
               if (GAMMA_THR[mid[c]] <= q_ff[c]) lo_in[c] = mid[c];
               else hi_in[c] = mid[c] - 8'd1;
            end
            if (cnt_ff == 5'd7) begin
               for (int c = 0; c < 3; c++) begin
                  if (zero_ff) g_in[c] = '0;
                  else if (GAMMA_THR[mid[c]] <= q_ff[c]) g_in[c] = mid[c];
                  else g_in[c] = lo_ff[c];
               end
               iss_in   = '0;
               state_in = ST_WALK;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         ST_WALK: begin
            if (ram_re) begin
               iss_in  = iss_ff + CW'(1);
               pend_in = 1'b1;
               pidx_in = iss_ff[AW-1:0];
               rdv_in  = valid_ff[iss_ff[AW-1:0]];
            end
            if (pend_ff && (pidx_ff == '0 || cand_dist < bestd_ff)) begin
               best_in  = pidx_ff;
               bestd_in = cand_dist;
            end
            if (!ram_re && !pend_ff) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            sqn_in   = {1'b0, 47'(bestd_ff * CONF_SCALE)};
            sqrem_in = '0;
            root_in  = '0;
            cnt_in   = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            sqn_in = {sqn_ff[45:0], 2'b00};
            if (sq_rn >= sq_trial) begin
               sqrem_in = 26'(sq_rn - sq_trial);
               root_in  = {root_ff[22:0], 1'b1};
            end else begin
               sqrem_in = sq_rn[25:0];
               root_in  = {root_ff[22:0], 1'b0};
            end
            if (cnt_ff == 5'd23) begin
               cnt_in   = '0;
               state_in = ST_KDIV;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
            // confidence stage starts once the root is complete
         end
         ST_KDIV: begin
            // registers the rounded root first, then multiplies it by the reciprocal
            if (cnt_ff == 5'd0) begin
               knum_in = knum_full;
               cnt_in  = 5'd1;
            end else begin
               kq_in    = kprod[48:CONF_SHIFT];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'd0, conf, bestd_ff, g_ff[0], g_ff[1], g_ff[2],
                               g_ff[2], g_ff[1], g_ff[0], INDEX_W'(best_ff)};
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         act_ff       <= ACT_W'(ACT_RESET);
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         for (int i = 0; i < MAX_COLORS; i++) valid_ff[i] <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         if (csr_wr_en) act_ff <= csr_wr_data;
         if (load_ok) valid_ff[ram_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      zero_ff  <= zero_in;
      max_ff   <= max_in;
      n_ff     <= n_in;
      iss_ff   <= iss_in;
      pidx_ff  <= pidx_in;
      rdv_ff   <= rdv_in;
      best_ff  <= best_in;
      bestd_ff <= bestd_in;
      sqn_ff   <= sqn_in;
      sqrem_ff <= sqrem_in;
      root_ff  <= root_in;
      knum_ff  <= knum_in;
      kq_ff    <= kq_in;
      rsp_data_ff <= rsp_data_in;
      for (int c = 0; c < 3; c++) begin
         drem_ff[c] <= drem_in[c];
         q_ff[c]    <= q_in[c];
         lo_ff[c]   <= lo_in[c];
         hi_ff[c]   <= hi_in[c];
         g_ff[c]    <= g_in[c];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   // a load item never produces a result
   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser == CMD_LOAD && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("result after load item");

   // table walk never reads past the active entries
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (iss_ff <= n_ff))
      else $error("table walk overran active count");

   // red field of the packed color agrees with the red channel of a new result
   a_packed: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (rsp_data_ff[51:28] == rsp_data_ff[27:4]
                               ? 1'b1 : rsp_data_ff[51:44] == rsp_data_ff[11:4]))
      else $error("packed color mismatch");

   // active count seen by the walk is within range
   a_n_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (n_ff != '0 && 32'(n_ff) <= MAX_COLORS))
      else $error("active count out of range");
`endif

endmodule

### tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rgbncc_pkg::*;

   // one classify result, fields as they sit in rsp_tdata
   typedef struct {
      logic [INDEX_W-1:0] idx;
      logic [CHAN_W-1:0]  red, green, blue;
      logic [23:0]        packed_rgb;
      logic [DIST_W-1:0]  dist_x4;
      logic [CONF_W-1:0]  conf;
   } color_result_type;

   // one input item plus an optional typed-in expected result
   typedef struct {
      logic               cmd;
      logic [3:0]         entry;
      logic [7:0]         rl, rh, gl, gh, bl, bh;
      logic [15:0]        clr, red, green, blue;
      bit                 has_exp;
      color_result_type   exp;
   } color_item_type;

   localparam int IDLE_LIMIT = 5000;
   localparam int SETTLE     = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = CMD_LOAD;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_wr_en = 1'b0;
   logic [ACT_W-1:0]      csr_wr_data = '0;

   rgb_nearest_color_classifier u_top (
      .clock, .reset,
      .req_tdata, .req_tuser, .req_tvalid, .req_tready,
      .rsp_tdata, .rsp_tvalid, .rsp_tready,
      .csr_wr_en, .csr_wr_data
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow copy of the color table and the search count
   logic [SUM_W-1:0] sum_red [MAX_COLORS_DEF];
   logic [SUM_W-1:0] sum_green [MAX_COLORS_DEF];
   logic [SUM_W-1:0] sum_blue [MAX_COLORS_DEF];
   logic [ACT_W-1:0] colors_searched;

   color_result_type pending_colors[$];
   int  mismatches = 0;
   bit  quiet = 1'b0;
   int  idle_cycles = 0;

   // largest v with v^5 * 2^(11*12) <= 255^5 * q^11
   function automatic logic [7:0] gamma_expand(logic [12:0] q);
      logic [255:0] rhs, lhs;
      int lo, hi, mid;
      rhs = 256'd1;
      repeat (11) rhs = rhs * 256'(q);
      repeat (5) rhs = rhs * 256'd255;
      lo = 0;
      hi = 255;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         lhs = 256'd1;
         repeat (5) lhs = lhs * 256'(mid);
         lhs = lhs << (11 * RATIO_BITS_DEF);
         if (lhs <= rhs) lo = mid;
         else hi = mid - 1;
      end
      return lo[7:0];
   endfunction

   function automatic logic [7:0] channel_gamma(logic [15:0] ch, logic [15:0] mx);
      logic [31:0] q;
      if (mx == 0) return 8'd0;
      q = ({16'd0, ch} << RATIO_BITS_DEF) / {16'd0, mx};
      return gamma_expand(q[12:0]);
   endfunction

   function automatic longint unsigned ceil_sqrt(longint unsigned n);
      longint unsigned r, t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= n) r = t;
      end
      if (r * r < n) r = r + 1;
      return r;
   endfunction

   // updates the table on a load, returns 1 with the result on a classify
   function automatic bit classify_color(color_item_type it, output color_result_type res);
      logic [15:0] mx;
      int n, d, bestd, dr, dg, db;
      longint unsigned root, k;
      res = '{default: '0};
      if (it.cmd == CMD_LOAD) begin
         sum_red[it.entry]   = SUM_W'(it.rl) + SUM_W'(it.rh);
         sum_green[it.entry] = SUM_W'(it.gl) + SUM_W'(it.gh);
         sum_blue[it.entry]  = SUM_W'(it.bl) + SUM_W'(it.bh);
         return 1'b0;
      end
      if (it.clr != 0) begin
         mx = it.red;
         if (it.green > mx) mx = it.green;
         if (it.blue > mx) mx = it.blue;
         res.red   = channel_gamma(it.red, mx);
         res.green = channel_gamma(it.green, mx);
         res.blue  = channel_gamma(it.blue, mx);
      end
      n = int'(colors_searched);
      if (n == 0) n = 1;
      if (n > MAX_COLORS_DEF) n = MAX_COLORS_DEF;
      bestd = 0;
      for (int i = 0; i < n; i++) begin
         dr = 2 * int'(res.red) - int'(sum_red[i]);
         dg = 2 * int'(res.green) - int'(sum_green[i]);
         db = 2 * int'(res.blue) - int'(sum_blue[i]);
         d = dr * dr + dg * dg + db * db;
         if (i == 0 || d < bestd) begin
            bestd = d;
            res.idx = INDEX_W'(i);
         end
      end
      root = ceil_sqrt(longint'(bestd) * 100000000);
      k = (root + 8833) / 8834;
      res.conf = (k >= 1000) ? 10'd0 : 10'(1000 - k);
      res.dist_x4 = DIST_W'(bestd);
      res.packed_rgb = {res.red, res.green, res.blue};
      return 1'b1;
   endfunction

   function automatic color_item_type load_item(int e, int rl, int rh, int gl, int gh,
                                                int bl, int bh);
      color_item_type it;
      it = '{default: '0};
      it.cmd = CMD_LOAD;
      it.entry = 4'(e);
      it.rl = 8'(rl); it.rh = 8'(rh); it.gl = 8'(gl); it.gh = 8'(gh);
      it.bl = 8'(bl); it.bh = 8'(bh);
      return it;
   endfunction

   function automatic color_item_type sample_item(int c, int r, int g, int b);
      color_item_type it;
      it = '{default: '0};
      it.cmd = CMD_CLASSIFY;
      it.clr = 16'(c); it.red = 16'(r); it.green = 16'(g); it.blue = 16'(b);
      return it;
   endfunction

   function automatic color_result_type typed_result(int idx, int r, int g, int b,
                                                     int dist_x4, int conf);
      color_result_type res;
      res.idx = INDEX_W'(idx);
      res.red = CHAN_W'(r); res.green = CHAN_W'(g); res.blue = CHAN_W'(b);
      res.packed_rgb = {res.red, res.green, res.blue};
      res.dist_x4 = DIST_W'(dist_x4); res.conf = CONF_W'(conf);
      return res;
   endfunction

   function automatic color_item_type random_item();
      color_item_type it;
      int mode;
      it.has_exp = 1'b0;
      it.exp = '{default: '0};
      it.cmd = ($urandom_range(0, 9) < 3) ? CMD_LOAD : CMD_CLASSIFY;
      it.entry = 4'($urandom);
      {it.rl, it.rh, it.gl, it.gh} = $urandom;
      {it.bl, it.bh, it.clr} = $urandom;
      {it.red, it.green} = $urandom;
      it.blue = 16'($urandom);
      mode = int'($urandom_range(0, 9));
      // skew some samples toward the special cases and small counts
      if (mode == 0) it.clr = 0;
      else if (mode == 1) {it.red, it.green, it.blue} = '0;
      else if (mode == 2) begin
         it.red = 16'($urandom_range(0, 20));
         it.green = 16'($urandom_range(0, 20));
         it.blue = 16'($urandom_range(0, 20));
      end else if (mode == 3) it.green = it.red;
      return it;
   endfunction

   // hand one item to the block, push the prediction at acceptance
   task automatic send_color_item(color_item_type it);
      color_result_type res;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.cmd;
      req_tdata  <= {4'd0, it.blue, it.green, it.red, it.clr,
                     it.bh, it.bl, it.gh, it.gl, it.rh, it.rl, it.entry};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      if (classify_color(it, res)) begin
         if (it.has_exp) pending_colors.push_back(it.exp);
         else pending_colors.push_back(res);
      end
   endtask

   task automatic drain_colors();
      req_tvalid <= 1'b0;
      while (pending_colors.size() != 0) @(posedge clock);
      // a trailing load item may still be in flight
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_colors_searched(logic [ACT_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      colors_searched = v;
   endtask

   // receiver stall bursts
   int rsp_stall = 0;
   always @(posedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         rsp_stall <= int'($urandom_range(0, 7));
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // inputs are stable at the falling edge, so check the handshake there
   always @(negedge clock) begin
      color_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.idx        = rsp_tdata[3:0];
         got.red        = rsp_tdata[11:4];
         got.green      = rsp_tdata[19:12];
         got.blue       = rsp_tdata[27:20];
         got.packed_rgb = rsp_tdata[51:28];
         got.dist_x4    = rsp_tdata[71:52];
         got.conf       = rsp_tdata[81:72];
         if (pending_colors.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item %h", rsp_tdata);
         end else begin
            want = pending_colors.pop_front();
            if (got.idx !== want.idx || got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.packed_rgb !== want.packed_rgb ||
                got.dist_x4 !== want.dist_x4 || got.conf !== want.conf) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"result mismatch: exp idx %0d rgb %h/%h/%h pk %h d %0d c %0d,",
                            " got idx %0d rgb %h/%h/%h pk %h d %0d c %0d"},
                           want.idx, want.red, want.green, want.blue, want.packed_rgb,
                           want.dist_x4, want.conf, got.idx, got.red, got.green, got.blue,
                           got.packed_rgb, got.dist_x4, got.conf);
            end
         end
      end
   end

   // watchdog on cycles where no item moves on either side
   always @(negedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   color_item_type   directed[$];
   logic [ACT_W-1:0] phase_counts[7];

   initial begin
      color_item_type it;
      for (int i = 0; i < MAX_COLORS_DEF; i++) begin
         sum_red[i] = '0; sum_green[i] = '0; sum_blue[i] = '0;
      end
      colors_searched = ACT_W'(ACT_RESET);

      // after reset: dark sample against an all-zero table
      it = sample_item(0, 1000, 2000, 3000);
      it.has_exp = 1'b1; it.exp = typed_result(0, 0, 0, 0, 0, 1000);
      directed.push_back(it);
      directed.push_back(load_item(0, 255, 255, 255, 255, 255, 255));
      // full white lands exactly on entry 0
      it = sample_item(1, 65535, 65535, 65535);
      it.has_exp = 1'b1; it.exp = typed_result(0, 255, 255, 255, 0, 1000);
      directed.push_back(it);
      // all channels zero: entry 0 is far, entry 1 is the first zero entry
      it = sample_item(65535, 0, 0, 0);
      it.has_exp = 1'b1; it.exp = typed_result(1, 0, 0, 0, 0, 1000);
      directed.push_back(it);
      directed.push_back(load_item(15, 0, 255, 255, 0, 128, 127));
      directed.push_back(load_item(1, 10, 20, 30, 40, 50, 60));
      directed.push_back(sample_item(100, 65535, 0, 0));
      directed.push_back(sample_item(5, 1, 0, 0));
      directed.push_back(sample_item(65535, 1, 65535, 32768));
      directed.push_back(sample_item(1, 12345, 12345, 12345));
      directed.push_back(sample_item(7, 0, 0, 1));
      directed.push_back(load_item(7, 128, 127, 1, 254, 200, 100));
      directed.push_back(sample_item(43690, 43690, 21845, 4096));
      // classify with load fields set, load with count fields set
      it = sample_item(300, 500, 400, 300);
      it.entry = 15; it.rl = 8'hff; it.bh = 8'haa;
      directed.push_back(it);
      it = load_item(3, 1, 2, 3, 4, 5, 6);
      it.clr = 16'hffff; it.red = 16'h5555;
      directed.push_back(it);
      directed.push_back(sample_item(2, 64, 128, 255));

      phase_counts = '{5'd1, 5'd0, 5'd31, 5'd8, 5'd2, 5'd0, 5'd16};
      phase_counts[5] = ACT_W'($urandom_range(1, 31));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_color_item(directed[i]);

      foreach (phase_counts[p]) begin
         drain_colors();
         write_colors_searched(phase_counts[p]);
         if (p == 6) quiet = 1'b1;
         if (phase_counts[p] == 1) begin
            // farthest possible sample from the only searched entry
            send_color_item(load_item(0, 255, 255, 255, 255, 255, 255));
            send_color_item(sample_item(0, 0, 0, 0));
         end
         repeat (93) send_color_item(random_item());
      end

      drain_colors();
      if (mismatches == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
